@@ design/lnr_pkg.sv @@
// ----------------------------------------------------------------------------
// lnr_pkg
// Shared widths, codes and reset values for the row normalization core.
// ----------------------------------------------------------------------------
package lnr_pkg;

  localparam int LNR_MAX_ROW = 64;

  localparam int IDX_W  = 6;
  localparam int DATA_W = 16;
  localparam int LEN_W  = 7;

  localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = 7'd64;

  localparam logic OP_ENTRY  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic signed [DATA_W-1:0] SCALE_RESET = 16'sd4096;
  localparam logic signed [DATA_W-1:0] SHIFT_RESET = 16'sd0;

  localparam int SUM_W  = 22;
  localparam int SQ_W   = 37;
  localparam int VAR_W  = 44;
  localparam int DEV_W  = 24;
  localparam int T_W    = 57;
  localparam int NORM_W = 42;
  localparam int PROD_W = 58;
  localparam int ACC_W  = 32;

  localparam int DIV_N_W   = 64;
  localparam int DIV_D_W   = 32;
  localparam int DIV_STEPS = 64;
  localparam int SQRT_STEPS = 32;

endpackage

@@ design/layer_normalization_row_core.sv @@
// ----------------------------------------------------------------------------
// layer_normalization_row_core
// Collects rows of Q8.8 samples, then emits each element normalized by the
// row mean and inverse standard deviation, scaled and shifted per element.
// ----------------------------------------------------------------------------
//  channel | signals                                         | dir
//  in      | in_valid in_ready opcode entry_index            | in
//          | sample_value scale_value shift_value            |
//  out     | out_valid out_ready result_value result_index   | out
//          | last_of_row                                     |
//  cfg     | cfg_valid cfg_ready cfg_data (row_length)       | in
//
// Items are taken only while the core is idle. The last sample of a row
// starts the statistics (two passes of the shared bit-serial divider and
// the bit-serial square root), then one divider pass for each element.
// No input item is taken during that work; a stalled output holds the pass.
// Reset restores unit scale and zero shift through per-entry valid bits.
module layer_normalization_row_core
  import lnr_pkg::*;
#(
  parameter int MAX_ROW = LNR_MAX_ROW
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     opcode,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [DATA_W-1:0] sample_value,
  input  logic signed [DATA_W-1:0] scale_value,
  input  logic signed [DATA_W-1:0] shift_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] result_value,
  output logic [IDX_W-1:0]         result_index,
  output logic                     last_of_row,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LEN_W-1:0]         cfg_data
);

  localparam int IW = $clog2(MAX_ROW);
  localparam int CW = $clog2(MAX_ROW + 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_VMUL   = 13'b0000000000010,
    S_VSUB   = 13'b0000000000100,
    S_DVAR   = 13'b0000000001000,
    S_DINV   = 13'b0000000010000,
    S_SQRT   = 13'b0000000100000,
    S_RD     = 13'b0000001000000,
    S_DEV    = 13'b0000010000000,
    S_PROD   = 13'b0000100000000,
    S_DSTART = 13'b0001000000000,
    S_DIV    = 13'b0010000000000,
    S_SCL    = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t st;

  logic [LEN_W-1:0] row_length;
  logic [CW-1:0]    eff_len;
  logic [CW-1:0]    fill;
  logic [CW-1:0]    fill_inc;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]  sumsq;

  logic [CW-1:0]           n_r;
  logic signed [SUM_W-1:0] s_r;
  logic [SQ_W-1:0]         q_r;
  logic [VAR_W-1:0]        nq;
  logic [VAR_W-1:0]        ss;
  logic [2*CW-1:0]         nsq;
  logic [DIV_D_W-1:0]      inv;

  logic signed [DATA_W-1:0] sample_mem [MAX_ROW];
  logic signed [DATA_W-1:0] scale_mem  [MAX_ROW];
  logic signed [DATA_W-1:0] shift_mem  [MAX_ROW];
  logic [MAX_ROW-1:0]       scale_ok;
  logic signed [DATA_W-1:0] sample_rd;
  logic signed [DATA_W-1:0] scale_rd;
  logic signed [DATA_W-1:0] shift_rd;
  logic                     ok_rd;

  logic [CW-1:0]             el_i;
  logic signed [DEV_W-1:0]   dev;
  logic signed [DATA_W-1:0]  scl;
  logic signed [DATA_W-1:0]  shf;
  logic signed [T_W-1:0]     t;
  logic                      t_neg;
  logic signed [NORM_W-1:0]  norm;
  logic signed [PROD_W-1:0]  prod;

  logic [DIV_N_W-1:0] div_quo;
  logic [DIV_D_W-1:0] div_rem;
  logic [DIV_D_W-1:0] div_den;
  logic [6:0]         div_cnt;
  logic               div_load;
  logic [DIV_N_W-1:0] div_num_in;
  logic [DIV_D_W-1:0] div_den_in;
  logic [DIV_D_W:0]   rem_sh;
  logic               rem_take;

  logic [63:0] sq_a;
  logic [63:0] sq_res;
  logic [63:0] sq_bit;
  logic [5:0]  sq_cnt;
  logic [63:0] sq_trial;

  logic in_acc;
  logic is_sample;
  logic is_entry;
  logic row_done;
  logic out_load;
  logic signed [ACC_W-1:0] x_ext;
  logic signed [ACC_W-1:0] x_sq;
  logic signed [VAR_W:0]   var_diff;
  logic [DIV_D_W-1:0]      v_next;
  logic [T_W-2:0]          t_mag;
  logic [PROD_W-1:0]       p_mag;
  logic [29:0]             rq;
  logic signed [ACC_W-1:0] scaled;
  logic signed [ACC_W-1:0] r_sum;
  logic signed [DATA_W-1:0] r_sat;

  assign in_ready  = (st == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign is_sample = in_acc && (opcode == OP_SAMPLE);
  assign is_entry  = in_acc && (opcode == OP_ENTRY) &&
                     ({1'b0, entry_index} < (IDX_W+1)'(MAX_ROW));

  always_comb begin
    if (row_length == '0) begin
      eff_len = CW'(1);
    end else if (row_length > LEN_W'(MAX_ROW)) begin
      eff_len = CW'(MAX_ROW);
    end else begin
      eff_len = CW'(row_length);
    end
  end

  assign fill_inc = fill + CW'(1);
  assign row_done = fill_inc >= eff_len;
  assign x_ext    = ACC_W'(sample_value);
  assign x_sq     = x_ext * x_ext;
  assign var_diff = $signed({1'b0, nq}) - $signed({1'b0, ss});
  assign v_next   = div_quo[DIV_D_W-1:0] + DIV_D_W'(1);
  assign t_mag    = t[T_W-1] ? (T_W-1)'(-t) : (T_W-1)'(t);
  assign out_load = (st == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    div_load   = 1'b0;
    div_num_in = '0;
    div_den_in = '0;
    case (st)
      S_VSUB: begin
        div_load   = 1'b1;
        div_num_in = var_diff[VAR_W] ? '0 : DIV_N_W'(var_diff[VAR_W-1:0]);
        div_den_in = DIV_D_W'(nsq);
      end
      S_DVAR: begin
        div_load   = (div_cnt == '0);
        div_num_in = DIV_N_W'(1) << 62;
        div_den_in = v_next;
      end
      S_DSTART: begin
        div_load   = 1'b1;
        div_num_in = DIV_N_W'(t_mag) + (DIV_N_W'(n_r) << 6);
        div_den_in = DIV_D_W'(n_r) << 7;
      end
      default: begin
        div_load = 1'b0;
      end
    endcase
  end

  assign rem_sh   = {div_rem, div_quo[DIV_N_W-1]};
  assign rem_take = rem_sh >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (div_load) begin
      div_quo <= div_num_in;
      div_rem <= '0;
      div_den <= div_den_in;
      div_cnt <= 7'(DIV_STEPS);
    end else if (div_cnt != '0) begin
      div_rem <= rem_take ? DIV_D_W'(rem_sh - {1'b0, div_den}) : rem_sh[DIV_D_W-1:0];
      div_quo <= {div_quo[DIV_N_W-2:0], rem_take};
      div_cnt <= div_cnt - 7'd1;
    end
  end

  assign sq_trial = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
    end else if ((st == S_DINV) && (div_cnt == '0)) begin
      sq_a   <= div_quo;
      sq_res <= '0;
      sq_bit <= 64'(1) << 62;
      sq_cnt <= 6'(SQRT_STEPS);
    end else if (sq_cnt != '0) begin
      if (sq_a >= sq_trial) begin
        sq_a   <= sq_a - sq_trial;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
      sq_cnt <= sq_cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (is_sample) begin
      sample_mem[fill[IW-1:0]] <= sample_value;
    end
    if (is_entry) begin
      scale_mem[entry_index[IW-1:0]] <= scale_value;
      shift_mem[entry_index[IW-1:0]] <= shift_value;
    end
    sample_rd <= sample_mem[el_i[IW-1:0]];
    scale_rd  <= scale_mem[el_i[IW-1:0]];
    shift_rd  <= shift_mem[el_i[IW-1:0]];
    ok_rd     <= scale_ok[el_i[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_ok <= '0;
    end else if (is_entry) begin
      scale_ok[entry_index[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      row_length <= cfg_data;
    end
  end

  always_comb begin
    p_mag  = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    rq     = 30'((p_mag + (PROD_W'(1) << 27)) >> 28);
    scaled = prod[PROD_W-1] ? -ACC_W'(rq) : ACC_W'(rq);
    r_sum  = scaled + ACC_W'(shf);
    if (r_sum > ACC_W'(32767)) begin
      r_sat = 16'sh7fff;
    end else if (r_sum < -ACC_W'(32768)) begin
      r_sat = -16'sh8000;
    end else begin
      r_sat = r_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      fill  <= '0;
      sum   <= '0;
      sumsq <= '0;
      el_i  <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (is_sample) begin
            if (row_done) begin
              n_r   <= fill_inc;
              s_r   <= sum + SUM_W'(sample_value);
              q_r   <= sumsq + SQ_W'(unsigned'(x_sq));
              fill  <= '0;
              sum   <= '0;
              sumsq <= '0;
              st    <= S_VMUL;
            end else begin
              fill  <= fill_inc;
              sum   <= sum + SUM_W'(sample_value);
              sumsq <= sumsq + SQ_W'(unsigned'(x_sq));
            end
          end
        end
        S_VMUL: begin
          nq  <= VAR_W'(n_r) * VAR_W'(q_r);
          ss  <= VAR_W'(VAR_W'(s_r) * VAR_W'(s_r));
          nsq <= (2*CW)'(n_r) * (2*CW)'(n_r);
          st  <= S_VSUB;
        end
        S_VSUB: begin
          st <= S_DVAR;
        end
        S_DVAR: begin
          if (div_cnt == '0) begin
            st <= S_DINV;
          end
        end
        S_DINV: begin
          if (div_cnt == '0) begin
            st <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_cnt == '0) begin
            inv  <= sq_res[DIV_D_W-1:0];
            el_i <= '0;
            st   <= S_RD;
          end
        end
        S_RD: begin
          st <= S_DEV;
        end
        S_DEV: begin
          dev <= DEV_W'($signed({1'b0, n_r})) * DEV_W'(sample_rd) - DEV_W'(s_r);
          scl <= ok_rd ? scale_rd : SCALE_RESET;
          shf <= ok_rd ? shift_rd : SHIFT_RESET;
          st  <= S_PROD;
        end
        S_PROD: begin
          t     <= T_W'(dev) * T_W'($signed({1'b0, inv}));
          st    <= S_DSTART;
        end
        S_DSTART: begin
          t_neg <= t[T_W-1];
          st    <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt == '0) begin
            norm <= t_neg ? -NORM_W'(div_quo) : NORM_W'(div_quo);
            st   <= S_SCL;
          end
        end
        S_SCL: begin
          prod <= PROD_W'(norm) * PROD_W'(scl);
          st   <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            el_i <= el_i + CW'(1);
            st   <= (el_i + CW'(1) == n_r) ? S_IDLE : S_RD;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid    <= 1'b1;
      result_value <= r_sat;
      result_index <= IDX_W'(el_i);
      last_of_row  <= (el_i + CW'(1) == n_r);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill < CW'(MAX_ROW))
    else $error("fill count reached row capacity");

  a_div_only_in_div_states: assert property (@(posedge clk) disable iff (rst)
    (div_cnt != '0) |-> (st == S_DVAR || st == S_DINV || st == S_DIV))
    else $error("divider running outside a divide state");

  a_sqrt_done_before_pass: assert property (@(posedge clk) disable iff (rst)
    (st == S_RD) |-> (sq_cnt == '0))
    else $error("element pass started before square root finished");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && (el_i + CW'(1) == n_r)) |=> (st == S_IDLE))
    else $error("row end did not return to idle");

endmodule

@@ sim/layer_normalization_row_core_tb.sv @@
// ----------------------------------------------------------------------------
// layer_normalization_row_core_tb
// Drives scale/shift entries and rows of Q8.8 samples into the row
// normalization core, predicts every normalized element, and compares
// each output item field by field, under random idling and long stalls.
// ----------------------------------------------------------------------------
module layer_normalization_row_core_tb;
  import lnr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 400;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
    logic                     last;
  } element_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     opcode = OP_ENTRY;
  logic [IDX_W-1:0]         entry_index = '0;
  logic signed [DATA_W-1:0] sample_value = '0;
  logic signed [DATA_W-1:0] scale_value = '0;
  logic signed [DATA_W-1:0] shift_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] result_value;
  logic [IDX_W-1:0]         result_index;
  logic                     last_of_row;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [LEN_W-1:0]         cfg_data = '0;

  layer_normalization_row_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .entry_index(entry_index), .sample_value(sample_value),
    .scale_value(scale_value), .shift_value(shift_value),
    .out_valid(out_valid), .out_ready(out_ready), .result_value(result_value),
    .result_index(result_index), .last_of_row(last_of_row),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [LEN_W-1:0]         row_len_q;
  logic signed [DATA_W-1:0] samples_q [LNR_MAX_ROW];
  logic signed [DATA_W-1:0] scales_q  [LNR_MAX_ROW];
  logic signed [DATA_W-1:0] shifts_q  [LNR_MAX_ROW];
  int                       fill_q;
  longint                   sum_q;
  element_t                 pending_elems [$];

  int  mismatches = 0;
  int  elems_seen = 0;
  int  items_sent = 0;
  int  rows_done = 0;
  int  cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > a) bitv >>= 2;
    while (bitv != 0) begin
      if (a >= res + bitv) begin
        a -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic void normalize_row();
    longint n, sq, varnum, inv, dev, norm, scaled, r;
    longint unsigned v;
    element_t e;
    n = fill_q;
    sq = 0;
    for (int i = 0; i < fill_q; i++) sq += longint'(samples_q[i]) * longint'(samples_q[i]);
    varnum = n * sq - sum_q * sum_q;
    if (varnum < 0) varnum = 0;
    v = longint'(varnum / (n * n)) + 1;
    inv = int_sqrt((64'd1 << 62) / v);
    for (int i = 0; i < fill_q; i++) begin
      dev = n * longint'(samples_q[i]) - sum_q;
      norm = round_div(dev * inv, n * 128);
      scaled = round_div(norm * longint'(scales_q[i]), 64'sd1 <<< 28);
      r = scaled + longint'(shifts_q[i]);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      e.value = r[DATA_W-1:0];
      e.index = i[IDX_W-1:0];
      e.last = (i + 1 == fill_q);
      pending_elems.push_back(e);
    end
    rows_done++;
  endfunction

  function automatic void predict_item(logic op, logic [IDX_W-1:0] idx,
                                       logic signed [DATA_W-1:0] smp,
                                       logic signed [DATA_W-1:0] sc,
                                       logic signed [DATA_W-1:0] sh);
    int eff;
    if (op == OP_ENTRY) begin
      scales_q[idx] = sc;
      shifts_q[idx] = sh;
      return;
    end
    if (fill_q >= LNR_MAX_ROW) fill_q = 0;
    samples_q[fill_q] = smp;
    sum_q += longint'(smp);
    fill_q++;
    eff = (row_len_q == 0) ? 1 : (row_len_q > LNR_MAX_ROW) ? LNR_MAX_ROW : int'(row_len_q);
    if (fill_q >= eff) begin
      normalize_row();
      fill_q = 0;
      sum_q = 0;
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR @%0d: %s got %0d want %0d", cycles, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    element_t e;
    if (!rst && out_valid && out_ready) begin
      elems_seen++;
      if (pending_elems.size() == 0) begin
        report_mismatch("unexpected item, index", result_index, -1);
      end else begin
        e = pending_elems.pop_front();
        if (result_value !== e.value) report_mismatch("result_value", result_value, e.value);
        if (result_index !== e.index) report_mismatch("result_index", result_index, e.index);
        if (last_of_row !== e.last) report_mismatch("last_of_row", last_of_row, e.last);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready = 1'b0;
      hold_off--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] smp,
                           logic signed [DATA_W-1:0] sc, logic signed [DATA_W-1:0] sh);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    entry_index = idx;
    sample_value = smp;
    scale_value = sc;
    shift_value = sh;
    do @(posedge clk); while (!in_ready);
    predict_item(op, idx, smp, sc, sh);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_sample(logic signed [DATA_W-1:0] smp);
    send_item(OP_SAMPLE, IDX_W'($urandom), smp, DATA_W'($urandom), DATA_W'($urandom));
  endtask

  task automatic send_entry(logic [IDX_W-1:0] idx, logic signed [DATA_W-1:0] sc,
                            logic signed [DATA_W-1:0] sh);
    send_item(OP_ENTRY, idx, DATA_W'($urandom), sc, sh);
  endtask

  task automatic drain();
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_row_length(logic [LEN_W-1:0] len);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = len;
    do @(posedge clk); while (!cfg_ready);
    row_len_q = len;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_directed();
    write_row_length(7'd0);
    send_sample(16'sh7fff);
    write_row_length(7'd1);
    send_sample(-16'sd32768);
    send_entry(6'd0, -16'sd32768, 16'sh7fff);
    send_entry(6'd63, 16'sh7fff, -16'sd32768);
    send_entry(6'd1, 16'sh7fff, 16'sh7fff);
    write_row_length(7'd2);
    send_sample(-16'sd32768);
    send_sample(16'sh7fff);
    send_sample(16'sd5);
    send_sample(16'sd5);
    write_row_length(7'd3);
    send_sample(16'sd256);
    send_sample(-16'sd512);
    write_row_length(7'd1);
    send_sample(16'sd1000);
    send_entry(6'd0, 16'sd4096, 16'sd0);
    send_entry(6'd1, 16'sd4096, 16'sd0);
  endtask

  task automatic test_full_rows();
    write_row_length(7'd127);
    for (int i = 0; i < LNR_MAX_ROW; i++) send_sample((i % 2) ? 16'sh7fff : -16'sd32768);
    write_row_length(7'd64);
    for (int i = 0; i < LNR_MAX_ROW; i++) send_sample(DATA_W'($urandom));
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 4) begin
        if ($urandom_range(0, 9) == 0) write_row_length(LEN_W'($urandom_range(0, 127)));
        else write_row_length(LEN_W'($urandom_range(1, 8)));
      end
      if ($urandom_range(0, 99) < 20)
        send_entry(IDX_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
      else if ($urandom_range(0, 1))
        send_sample(DATA_W'($urandom));
      else
        send_sample($signed(16'($urandom_range(0, 2047))) - 16'sd1024);
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_row_length(7'd4);
    hold_off = 3000;
    for (int i = 0; i < 16; i++) send_sample(DATA_W'($urandom));
    drain();
    for (int i = 0; i < 8; i++) send_sample(DATA_W'($urandom));
    drain();
  endtask

  initial begin
    row_len_q = ROW_LENGTH_RESET;
    for (int i = 0; i < LNR_MAX_ROW; i++) begin
      samples_q[i] = '0;
      scales_q[i] = SCALE_RESET;
      shifts_q[i] = SHIFT_RESET;
    end
    fill_q = 0;
    sum_q = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_random_traffic(50, 6, 56);
    test_random_traffic(50, 56, 6);
    test_full_rows();
    test_random_traffic(50, 0, 0);
    drain();

    $display("Sent %0d items, checked %0d elements over %0d rows (lengths 0..127, stalls).",
             items_sent, elems_seen, rows_done);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
